// File: hdl/sdp_pkg.sv
// ----------------------------------------------------------------------------
// sdp_pkg
// shared widths and character codes of the signed decimal formatter
// ----------------------------------------------------------------------------
package sdp_pkg;

    localparam int VALUE_W     = 32;
    localparam int PREC_W      = 6;
    localparam int S_DATA_W    = 40;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_COUNT = 10;
    localparam int DIGIT_IDX_W = 4;
    localparam int QUOT_W      = 29;
    localparam int RECIP_SHIFT = 35;

    localparam logic [PREC_W-1:0]  MAX_PRECISION = 6'd63;
    localparam logic [VALUE_W-1:0] RECIP_TEN     = 32'hCCCC_CCCD;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_NINE     = 8'd57;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 8'd45;

endpackage

// File: hdl/signed_decimal_with_precision_unit.sv
// ----------------------------------------------------------------------------
// signed_decimal_with_precision_unit
// formats a signed 32-bit value as ascii decimal text with a minimum digit
// count, one character per output beat
// ----------------------------------------------------------------------------
// An input beat is taken only while the unit is idle. Digits are found least
// significant first by one shared reciprocal multiplier (divide by ten); for
// each digit, ST_MUL registers a 32x32 product, then ST_DIV takes quotient and
// remainder. A value has D digits (D is 1 to 10). Once they are found, it sends
// sign, zero padding and digits through a single output register at one beat
// per cycle while m_tready is high. The unit is ready again as soon as its final
// character sits in the output register. Zero at precision zero gives no
// beat and keeps the unit idle.
module signed_decimal_with_precision_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sdp_pkg::S_DATA_W-1:0]  s_tdata,   // value[31:0], precision[37:32], zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sdp_pkg::CHAR_W-1:0]    m_tdata,   // character[7:0]
    output logic                          m_tlast
);
    import sdp_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_EMIT} state_t;

    state_t                   state_reg;
    logic [VALUE_W-1:0]       mag_reg;
    logic [2*VALUE_W-1:0]     prod_reg;
    logic [PREC_W-1:0]        prec_reg;
    logic [PREC_W-1:0]        pad_reg;
    logic [DIGIT_IDX_W-1:0]   nd_reg;
    logic                     sign_reg;
    logic [3:0]               digits_reg [DIGIT_COUNT];
    logic                     m_tvalid_reg;
    logic [CHAR_W-1:0]        m_tdata_reg;
    logic                     m_tlast_reg;

    logic [VALUE_W-1:0]       in_value;
    logic [PREC_W-1:0]        in_prec;
    logic [QUOT_W-1:0]        quot;
    logic [VALUE_W-1:0]       times_ten;
    logic [VALUE_W-1:0]       rem_full;
    logic [DIGIT_IDX_W-1:0]   nd_inc;
    logic [DIGIT_IDX_W-1:0]   rd_idx;
    logic                     out_free;

    assign in_value  = s_tdata[VALUE_W-1:0];
    assign in_prec   = (s_tdata[VALUE_W +: PREC_W] > MAX_PRECISION) ? MAX_PRECISION
                                                                   : s_tdata[VALUE_W +: PREC_W];
    assign quot      = prod_reg[RECIP_SHIFT +: QUOT_W];
    assign times_ten = {quot[QUOT_W-1:0], 3'b000} + {2'b00, quot, 1'b0};
    assign rem_full  = mag_reg - times_ten;
    assign nd_inc    = nd_reg + 4'd1;
    assign rd_idx    = nd_reg - 4'd1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mag_reg      <= '0;
            prod_reg     <= '0;
            prec_reg     <= '0;
            pad_reg      <= '0;
            nd_reg       <= '0;
            sign_reg     <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                digits_reg[i] <= '0;
            end
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (s_tvalid && (in_value != '0 || in_prec != '0))
                    begin
                        sign_reg  <= in_value[VALUE_W-1];
                        mag_reg   <= in_value[VALUE_W-1] ? (~in_value + 32'd1) : in_value;
                        prec_reg  <= in_prec;
                        nd_reg    <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    prod_reg  <= mag_reg * RECIP_TEN;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    digits_reg[nd_reg] <= rem_full[3:0];
                    nd_reg             <= nd_inc;
                    mag_reg            <= {3'b000, quot};
                    if (quot == '0)
                    begin
                        pad_reg   <= (prec_reg > {2'b00, nd_inc}) ? (prec_reg - {2'b00, nd_inc})
                                                                  : '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        priority if (sign_reg)
                        begin
                            m_tdata_reg <= CHAR_MINUS;
                            m_tlast_reg <= 1'b0;
                            sign_reg    <= 1'b0;
                        end
                        else if (pad_reg != '0)
                        begin
                            m_tdata_reg <= CHAR_ZERO;
                            m_tlast_reg <= 1'b0;
                            pad_reg     <= pad_reg - 6'd1;
                        end
                        else
                        begin
                            m_tdata_reg <= CHAR_ZERO + {4'b0000, digits_reg[rd_idx]};
                            m_tlast_reg <= (nd_reg == 4'd1);
                            nd_reg      <= rd_idx;
                            if (nd_reg == 4'd1)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_rem_below_ten: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_full < 32'd10))
        else $error("remainder of divide by ten out of range");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == CHAR_MINUS || (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE)))
        else $error("output character is neither sign nor digit");

    a_last_not_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata != CHAR_MINUS))
        else $error("sign flagged as final character");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata[VALUE_W-1:0] != '0) |=> !s_tready)
        else $error("nonzero value accepted without busy period");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_decimal_with_precision_unit. A driver sends
// value and precision beats from a queue of pending items. A predictor builds
// the expected ascii text, sign then zero padding then digits, for each
// accepted beat. A monitor checks every output beat, character and tlast,
// against the oldest expected character. The run has a directed phase and
// random phases of varied sender idling and receiver stalling, and drains after each.
// ----------------------------------------------------------------------------
module testbench;

    import sdp_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed
    {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [CHAR_W-1:0]   m_tdata;
    logic                m_tlast;

    logic [S_DATA_W-1:0] pending_items[$];
    text_beat_t          expected_text[$];
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  mismatches = 0;
    int                  cycle_count = 0;

    signed_decimal_with_precision_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // value[31:0], precision[37:32], zero fill
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // character[7:0]
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // printf style "%.Nd" text of one value
    task automatic predict_text(input logic [S_DATA_W-1:0] item);
        logic [VALUE_W-1:0] value;
        logic [PREC_W-1:0]  prec;
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits[DIGIT_COUNT];
        logic [CHAR_W-1:0]  text[$];
        int                 nd;
        int                 i;
        value = item[VALUE_W-1:0];
        prec  = item[VALUE_W +: PREC_W];
        nd    = 0;
        if (prec > MAX_PRECISION)
            prec = MAX_PRECISION;
        if (value == '0 && prec == '0)
            return;
        mag = value[VALUE_W-1] ? (32'd0 - value) : value;
        if (mag == '0)
        begin
            digits[0] = 4'd0;
            nd = 1;
        end
        else
        begin
            while (mag != '0 && nd < DIGIT_COUNT)
            begin
                digits[nd] = 4'(mag % 32'd10);
                mag = mag / 32'd10;
                nd++;
            end
        end
        if (value[VALUE_W-1])
            text.push_back(CHAR_MINUS);
        for (i = nd; i < int'(prec); i++)
            text.push_back(CHAR_ZERO);
        for (i = nd - 1; i >= 0; i--)
            text.push_back(CHAR_ZERO + 8'(digits[i]));
        for (i = 0; i < text.size(); i++)
            expected_text.push_back('{ch: text[i], last: (i == text.size() - 1)});
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_text(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata  <= pending_items.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        text_beat_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected beat: char %0d last %0b", m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.ch || m_tlast !== want.last)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                                     want.ch, want.last, m_tdata, m_tlast);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL signed_decimal_with_precision_unit");
            $finish;
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_item(logic [VALUE_W-1:0] value,
                                                     logic [PREC_W-1:0] prec);
        return {2'b00, prec, value};
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        longint unsigned scale;
        logic [VALUE_W-1:0] v;
        int n;
        scale = 1;
        case ($urandom_range(7))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(99);
            4:
            begin
                n = $urandom_range(9);
                repeat (n) scale = scale * 10;
                v = 32'(scale) + 32'($urandom_range(2)) - 32'd1;
            end
            5:
            begin
                case ($urandom_range(4))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h0000_0001;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
                return v;
            end
            default:
            begin
                n = $urandom_range(1, 9);
                repeat (n) scale = scale * 10;
                v = 32'($urandom % scale);
            end
        endcase
        if ($urandom_range(1))
            v = 32'd0 - v;
        return v;
    endfunction

    function automatic logic [PREC_W-1:0] random_prec();
        if ($urandom_range(9) == 0)
            return PREC_W'($urandom_range(63));
        return PREC_W'($urandom_range(12));
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
            pending_items.push_back(pack_item(random_value(), random_prec()));
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_items.size() > 0 || s_tvalid || expected_text.size() > 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_items.push_back(pack_item(32'd0, 6'd0));
        pending_items.push_back(pack_item(32'd0, 6'd1));
        pending_items.push_back(pack_item(32'd0, 6'd63));
        pending_items.push_back(pack_item(32'd1, 6'd0));
        pending_items.push_back(pack_item(32'hFFFF_FFFF, 6'd0));
        pending_items.push_back(pack_item(32'h7FFF_FFFF, 6'd0));
        pending_items.push_back(pack_item(32'h8000_0000, 6'd0));
        pending_items.push_back(pack_item(32'h8000_0000, 6'd63));
        pending_items.push_back(pack_item(32'h7FFF_FFFF, 6'd63));
        pending_items.push_back(pack_item(32'h7FFF_FFFF, 6'd10));
        pending_items.push_back(pack_item(32'h8000_0000, 6'd11));
        pending_items.push_back(pack_item(32'd12345, 6'd3));
        pending_items.push_back(pack_item(32'd12345, 6'd5));
        pending_items.push_back(pack_item(32'd12345, 6'd6));
        pending_items.push_back(pack_item(-32'sd42, 6'd5));
        pending_items.push_back(pack_item(32'd9, 6'd1));
        pending_items.push_back(pack_item(32'd10, 6'd2));
        pending_items.push_back(pack_item(32'd999999999, 6'd0));
        pending_items.push_back(pack_item(32'd1000000000, 6'd0));
        pending_items.push_back(pack_item(-32'sd7, 6'd63));
        pending_items.push_back(pack_item(32'h5555_5555, 6'd42));
        pending_items.push_back(pack_item(32'hAAAA_AAAA, 6'd21));
        drain();

        send_idle_pct  = 57;
        recv_stall_pct = 0;
        queue_random(80);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 57;
        queue_random(40);
        drain();
        queue_random(40);
        drain();

        send_idle_pct  = 24;
        recv_stall_pct = 24;
        queue_random(85);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(85);
        drain();

        if (mismatches == 0 && expected_text.size() == 0)
            $display("PASS signed_decimal_with_precision_unit");
        else
            $display("FAIL signed_decimal_with_precision_unit");
        $finish;
    end

endmodule
